// ===== rtl/rejm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rejm_pkg
// Shared widths, register indexes and reset constants for the raster edge and
// junction map.
// ----------------------------------------------------------------------------
package rejm_pkg;

  localparam int COL_W       = 13;
  localparam int ROW_W       = 16;
  localparam int PIX_W       = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 8;

  localparam logic [COL_W-1:0] COLS_RESET   = 13'd4096;
  localparam logic [ROW_W-1:0] ROWS_RESET   = 16'd4096;
  localparam logic [PIX_W-1:0] NODATA_RESET = 32'hFFFF_8000;

  // more distinct values than this in the window marks a junction
  localparam logic [2:0] MAX_PLAIN_VALUES = 3'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RASTER_COLS   = 2'd0,
    CFG_RASTER_ROWS   = 2'd1,
    CFG_SOURCE_NODATA = 2'd2,
    CFG_NODATA_CODE   = 2'd3
  } cfg_idx_t;

endpackage

// ===== rtl/rejm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rejm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// A read and a write to the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
module rejm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/raster_edge_junction_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raster_edge_junction_map
// Walks the vertex grid of a raster in raster order and flags horizontal
// edges, vertical edges and junctions from the 2x2 window around each vertex.
//
//   channel  direction  words carried
//   s_*      in         one vertex slot: pixel value, mask flag
//   m_*      out        one flag set per slot, tlast on the final slot
//   cfg_*    in         register writes (cols, rows, source nodata, nodata code)
//
// one word in and one word out per cycle when neither side stalls
// a slot is registered with its row store read, then its flags in the output register
// the row above lives in a registered-read RAM of MAX_COLS entries; each non-padding
// slot reads and overwrites its own column in the same cycle, so no forwarding
// reset clears the counters and valids; the registers load their reset values
// a stalled output holds the compare stage, which then holds the input
// ----------------------------------------------------------------------------
module raster_edge_junction_map #(
  parameter int MAX_COLS   = 4096,
  parameter int VALUE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rejm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rejm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [rejm_pkg::IN_TDATA_W-1:0]     s_tdata,   // [31:0] pixel_value
  input  logic [rejm_pkg::IN_TUSER_W-1:0]     s_tuser,   // [0] in_mask
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [rejm_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [0] edge_horizontal,
                                                         // [1] edge_vertical,
                                                         // [2] junction, rest 0
  output logic                                m_tlast    // frame_last
);

  import rejm_pkg::*;

  localparam int AW = $clog2(MAX_COLS);
  localparam int LIM_W = 17;
  localparam logic [LIM_W-1:0] COLS_LIMIT = LIM_W'(MAX_COLS);

  // configuration
  logic [COL_W-1:0] raster_cols;
  logic [ROW_W-1:0] raster_rows;
  logic [PIX_W-1:0] source_nodata;
  logic [PIX_W-1:0] nodata_code;

  // slot position and neighbour history
  logic [COL_W-1:0]      col_count;
  logic [ROW_W-1:0]      row_count;
  logic [VALUE_BITS-1:0] left_value;
  logic [VALUE_BITS-1:0] upper_left_value;

  // compare stage
  logic                  s1_valid;
  logic [VALUE_BITS-1:0] s1_lr;
  logic [VALUE_BITS-1:0] s1_left;
  logic                  s1_first_col;
  logic                  s1_first_row;
  logic                  s1_pad_col;
  logic                  s1_pad_row;

  // output register
  logic                  out_valid;
  logic [2:0]            out_flags;
  logic                  out_last;

  logic                  accept;
  logic                  s1_adv;
  logic [LIM_W-1:0]      cols_ext;
  logic [LIM_W-1:0]      eff_cols;
  logic                  pad_col;
  logic                  pad_row;
  logic [VALUE_BITS-1:0] nd;
  logic [VALUE_BITS-1:0] lr0;
  logic [AW-1:0]         col_addr;
  logic [VALUE_BITS-1:0] above_rdata;

  logic [VALUE_BITS-1:0] ur;
  logic [VALUE_BITS-1:0] ll;
  logic [VALUE_BITS-1:0] ul;
  logic [VALUE_BITS-1:0] lr;
  logic [2:0]            n_distinct;
  logic                  junc;

  always_ff @(posedge clk) begin
    if (rst) begin
      raster_cols   <= COLS_RESET;
      raster_rows   <= ROWS_RESET;
      source_nodata <= NODATA_RESET;
      nodata_code   <= NODATA_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RASTER_COLS:   raster_cols   <= cfg_wdata[COL_W-1:0];
        CFG_RASTER_ROWS:   raster_rows   <= cfg_wdata[ROW_W-1:0];
        CFG_SOURCE_NODATA: source_nodata <= cfg_wdata[PIX_W-1:0];
        CFG_NODATA_CODE:   nodata_code   <= cfg_wdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign s1_adv   = s1_valid && (!out_valid || m_tready);
  assign s_tready = !s1_valid || s1_adv;
  assign accept   = s_tvalid && s_tready;

  // slot classification
  always_comb begin
    cols_ext = LIM_W'(raster_cols);
    eff_cols = (cols_ext > COLS_LIMIT) ? COLS_LIMIT : cols_ext;
    pad_col  = LIM_W'(col_count) >= eff_cols;
    pad_row  = row_count >= raster_rows;
    nd       = nodata_code[VALUE_BITS-1:0];
    if (pad_col || pad_row || !s_tuser[0] || (s_tdata == source_nodata)) begin
      lr0 = nd;
    end else begin
      lr0 = s_tdata[VALUE_BITS-1:0];
    end
    col_addr = AW'(col_count);
  end

  rejm_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_COLS)
  ) u_row_store (
    .clk   (clk),
    .we    (accept && !pad_col),
    .waddr (col_addr),
    .wdata (lr0),
    .re    (accept),
    .raddr (col_addr),
    .rdata (above_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count  <= '0;
      row_count  <= '0;
      left_value <= NODATA_RESET[VALUE_BITS-1:0];
    end else if (accept) begin
      left_value <= lr0;
      if (pad_col) begin
        col_count <= '0;
        if (pad_row) begin
          row_count <= '0;
        end else begin
          row_count <= row_count + 1'b1;
        end
      end else begin
        col_count <= col_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_lr        <= lr0;
      s1_left      <= left_value;
      s1_first_col <= (col_count == '0);
      s1_first_row <= (row_count == '0);
      s1_pad_col   <= pad_col;
      s1_pad_row   <= pad_row;
    end
  end

  // window compare
  always_comb begin
    lr = s1_lr;
    ur = (s1_first_row || s1_pad_col) ? nd : above_rdata;
    ll = (s1_first_col || s1_pad_row) ? nd : s1_left;
    ul = (s1_first_col || s1_first_row) ? nd : upper_left_value;
    n_distinct = 3'd1
               + {2'b00, (ur != ul)}
               + {2'b00, (lr != ul) && (lr != ur)}
               + {2'b00, (ll != ul) && (ll != ur) && (ll != lr)};
    junc = ((ul == lr) && (ur != ul) && (ll != ul))
        || ((ur == ll) && (ul != ur) && (lr != ur))
        || (n_distinct > MAX_PLAIN_VALUES);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_left_value <= NODATA_RESET[VALUE_BITS-1:0];
    end else if (s1_adv) begin
      upper_left_value <= ur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_flags <= {junc, (ll != lr), (ur != lr)};
      out_last  <= s1_pad_col && s1_pad_row;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_TDATA_W - 3){1'b0}}, out_flags};
  assign m_tlast  = out_last;

endmodule

// ===== rtl/rejm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rejm_checker
// Port-level checks on the result stream of the raster edge and junction map.
// ----------------------------------------------------------------------------
module rejm_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [rejm_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input logic                              m_tlast
);

  import rejm_pkg::*;

  // a stalled word stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result word withdrawn while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("result word changed while stalled");

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result word offered straight after reset");

  // the final slot is padding on both sides, so it carries no edge
  a_last_no_edge: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> (m_tdata[0] == 1'b0) && (m_tdata[1] == 1'b0))
    else $error("edge flagged on the final slot");

  // a junction needs lower-right to differ from a neighbour
  a_junc_has_edge: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> m_tdata[0] || m_tdata[1])
    else $error("junction without any edge");

endmodule

bind raster_edge_junction_map rejm_checker u_rejm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Streams whole vertex frames of various raster sizes through the edge and
// junction map and checks every flag word against a cycle-free model of the
// 2x2 window, with bursty input and a stalling output.
// ----------------------------------------------------------------------------
module tb;
  import rejm_pkg::*;

  typedef struct {
    logic [31:0] pix;
    logic        mask;
  } slot_t;

  typedef struct {
    logic horiz;
    logic vert;
    logic junc;
    logic frame_end;
  } flag_set_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;   // [31:0] pixel_value
  logic [IN_TUSER_W-1:0]  s_tuser   = '0;   // [0] in_mask
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;          // [0] edge_h, [1] edge_v, [2] junction
  logic                   m_tlast;

  raster_edge_junction_map dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // window model state
  logic [COL_W-1:0] raster_cols   = COLS_RESET;
  logic [ROW_W-1:0] raster_rows   = ROWS_RESET;
  logic [PIX_W-1:0] source_nodata = NODATA_RESET;
  logic [PIX_W-1:0] nodata_code   = NODATA_RESET;
  logic [PIX_W-1:0] above_row [4096];
  logic [PIX_W-1:0] upper_left_px = NODATA_RESET;
  logic [PIX_W-1:0] left_px       = NODATA_RESET;
  logic [ROW_W-1:0] row_n = '0;
  logic [COL_W-1:0] col_n = '0;

  slot_t     slot_q[$];
  flag_set_t flag_sets_due[$];
  int        err_count = 0;

  task automatic flag_mismatch(input string what);
    err_count++;
    $display("mismatch at %0t ns: %s", $time, what);
  endtask

  function automatic logic [COL_W-1:0] cols_in_store();
    return (raster_cols > 13'd4096) ? 13'd4096 : raster_cols;
  endfunction

  // one vertex slot through the window: flags for this slot, then advance
  function automatic void predict_flags(input logic [31:0] pix, input logic mask);
    logic      pad_col, pad_row;
    logic [31:0] lr, ur, ll, ul;
    int        distinct;
    flag_set_t fs;
    pad_col = col_n >= cols_in_store();
    pad_row = row_n >= raster_rows;
    lr = (pad_col || pad_row || !mask || pix == source_nodata) ? nodata_code : pix;
    ur = (row_n == 0 || pad_col) ? nodata_code : above_row[col_n];
    ll = (col_n == 0 || pad_row) ? nodata_code : left_px;
    ul = (col_n == 0 || row_n == 0) ? nodata_code : upper_left_px;
    distinct = 1;
    if (ur != ul) distinct++;
    if (lr != ul && lr != ur) distinct++;
    if (ll != ul && ll != ur && ll != lr) distinct++;
    fs.horiz = ur != lr;
    fs.vert  = ll != lr;
    fs.junc  = (ul == lr && ur != ul && ll != ul) ||
               (ur == ll && ul != ur && lr != ur) || distinct > int'(MAX_PLAIN_VALUES);
    fs.frame_end = pad_row && pad_col;
    flag_sets_due.insert(flag_sets_due.size(), fs);
    if (!pad_col) above_row[col_n] = lr;
    upper_left_px = ur;
    left_px = lr;
    if (pad_col) begin
      col_n = '0;
      row_n = pad_row ? '0 : row_n + 1'b1;
    end else begin
      col_n = col_n + 1'b1;
    end
  endfunction

  // sender: bursts of random length with random gaps
  int    burst_left = 0;
  int    idle_left  = 0;
  slot_t next_slot;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_flags(s_tdata, s_tuser[0]);
      if (!s_tvalid || s_tready) begin
        if (idle_left > 0) begin
          idle_left--;
          s_tvalid <= 1'b0;
        end else if (slot_q.size() != 0) begin
          next_slot = slot_q.pop_front();
          s_tdata  <= next_slot.pix;
          s_tuser  <= next_slot.mask;
          s_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 47);
            idle_left  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stalls follow a 32-bit pattern, reloaded in one of four moods
  logic [31:0] stall_pat = '1;
  logic [4:0]  pat_pos   = '0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (pat_pos == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pat = '1;
          1: stall_pat = $urandom;
          2: stall_pat = $urandom | $urandom;
          default: stall_pat = $urandom & $urandom;
        endcase
      end
      m_tready <= stall_pat[pat_pos];
      pat_pos = pat_pos + 1'b1;
    end
  end

  // flag word check
  flag_set_t want;

  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      if (flag_sets_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected word %h last %b", m_tdata, m_tlast));
      end else begin
        want = flag_sets_due.pop_front();
        if (m_tdata[0] !== want.horiz)
          flag_mismatch($sformatf("edge_h got %b want %b", m_tdata[0], want.horiz));
        if (m_tdata[1] !== want.vert)
          flag_mismatch($sformatf("edge_v got %b want %b", m_tdata[1], want.vert));
        if (m_tdata[2] !== want.junc)
          flag_mismatch($sformatf("junction got %b want %b", m_tdata[2], want.junc));
        if (m_tdata[7:3] !== 5'd0)
          flag_mismatch($sformatf("spare bits got %b", m_tdata[7:3]));
        if (m_tlast !== want.frame_end)
          flag_mismatch($sformatf("tlast got %b want %b", m_tlast, want.frame_end));
      end
    end
  end

  // stimulus
  logic [31:0] palette [4];
  int          random_words = 0;

  task automatic wait_idle();
    while (slot_q.size() != 0 || s_tvalid || flag_sets_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_raster(input logic [12:0] cols, input logic [15:0] rows,
                                input logic [31:0] src, input logic [31:0] code);
    // junk above the register width must be dropped
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RASTER_COLS;
    cfg_wdata <= {19'($urandom), cols};
    @(posedge clk);
    cfg_index <= CFG_RASTER_ROWS;
    cfg_wdata <= {16'($urandom), rows};
    @(posedge clk);
    cfg_index <= CFG_SOURCE_NODATA;
    cfg_wdata <= src;
    @(posedge clk);
    cfg_index <= CFG_NODATA_CODE;
    cfg_wdata <= code;
    @(posedge clk);
    cfg_we <= 1'b0;
    raster_cols   = cols;
    raster_rows   = rows;
    source_nodata = src;
    nodata_code   = code;
  endtask

  function automatic logic [31:0] pick_pixel();
    if ($urandom_range(0, 6) == 0) return $urandom;
    return palette[$urandom_range(0, 3)];
  endfunction

  // a whole frame of random content over the current raster size
  task automatic queue_frame();
    int n;
    slot_t s;
    n = (int'(raster_rows) + 1) * (int'(cols_in_store()) + 1);
    for (int k = 0; k < 4; k++)
      palette[k] = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 3);
    if ($urandom_range(0, 2) == 0) palette[0] = source_nodata;
    if ($urandom_range(0, 3) == 0) palette[1] = nodata_code;
    for (int k = 0; k < n; k++) begin
      s.pix  = pick_pixel();
      s.mask = $urandom_range(0, 7) != 0;
      slot_q.insert(slot_q.size(), s);
    end
    random_words += n;
  endtask

  function automatic logic [31:0] pick_nodata();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  slot_t ds;

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // checkerboard rows, then source nodata, a masked pixel and a real value
    // equal to the nodata code; the frame is split so the sender runs dry
    program_raster(13'd3, 16'd3, 32'h7FFF_FFFF, 32'h8000_0000);
    for (int r = 0; r <= 3; r++) begin
      for (int c = 0; c <= 3; c++) begin
        ds.mask = 1'b1;
        ds.pix  = $urandom;
        if (r < 2 && c < 3)
          ds.pix = ((r + c) % 2 == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
        else if (r == 2 && c == 0)
          ds.pix = 32'h7FFF_FFFF;
        else if (r == 2 && c == 1)
          ds.mask = 1'b0;
        else if (r == 2 && c == 2)
          ds.pix = 32'h8000_0000;
        else
          ds.mask = $urandom_range(0, 1);
        slot_q.insert(slot_q.size(), ds);
      end
      if (r == 1) wait_idle();
    end
    wait_idle();

    // no columns: one padding slot per row
    program_raster(13'd0, 16'd2, 32'h0000_0000, 32'hFFFF_FFFF);
    repeat (3) begin
      ds.pix = $urandom; ds.mask = $urandom_range(0, 1);
      slot_q.insert(slot_q.size(), ds);
    end
    wait_idle();

    // no rows: a single padding row
    program_raster(13'd2, 16'd0, 32'hFFFF_FFFF, 32'h0000_0000);
    repeat (3) begin
      ds.pix = $urandom; ds.mask = 1'b1;
      slot_q.insert(slot_q.size(), ds);
    end
    wait_idle();

    while (random_words < 420) begin
      program_raster(($urandom_range(0, 9) == 0) ? 13'($urandom_range(13, 40))
                                                 : 13'($urandom_range(1, 12)),
                     16'($urandom_range(1, 8)), pick_nodata(), pick_nodata());
      queue_frame();
      wait_idle();
    end

    // size extremes: smallest raster, a wide raster of two rows and a tall
    // raster with no columns
    program_raster(13'd1, 16'd1, pick_nodata(), pick_nodata());
    queue_frame();
    wait_idle();
    program_raster(13'd40, 16'd2, pick_nodata(), pick_nodata());
    queue_frame();
    wait_idle();
    program_raster(13'd0, 16'd40, pick_nodata(), pick_nodata());
    queue_frame();
    wait_idle();

    repeat (10) @(posedge clk);
    if (flag_sets_due.size() != 0)
      flag_mismatch($sformatf("%0d flag words never arrived", flag_sets_due.size()));
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
